### rtl/isis_hdr_pkg.sv
// ----------------------------------------------------------------------------
// isis_hdr_pkg
// Constants, codes and helper functions for the IS-IS header checker and
// TLV walker.
// ----------------------------------------------------------------------------
package isis_hdr_pkg;

  localparam int SYS_ID_BYTES = 6;

  // Header field values
  localparam logic [7:0] NLPID_IS     = 8'd131;
  localparam logic [7:0] TYPE_MASK    = 8'h1F;
  localparam logic [7:0] VERSION_ONE  = 8'd1;
  localparam logic [7:0] ID_LEN_SYS   = 8'(SYS_ID_BYTES);
  localparam logic [7:0] ID_LEN_DFLT  = 8'd0;
  localparam logic [7:0] AREAS_BAD    = 8'd255;
  localparam logic [7:0] CIRC_NONE    = 8'd0;
  localparam logic [7:0] CIRC_L1      = 8'd1;
  localparam logic [7:0] CIRC_L2      = 8'd2;
  localparam logic [7:0] CIRC_L12     = 8'd3;

  // Fixed header lengths
  localparam logic [7:0] LAN_HDR  = 8'(15 + (SYS_ID_BYTES << 1));
  localparam logic [7:0] PTP_HDR  = 8'(14 + SYS_ID_BYTES);
  localparam logic [7:0] LSP_HDR  = 8'(21 + SYS_ID_BYTES);
  localparam logic [7:0] CSNP_HDR = 8'd33;

  // PDU types
  localparam logic [4:0] PT_L1_LAN_HELLO = 5'd15;
  localparam logic [4:0] PT_L2_LAN_HELLO = 5'd16;
  localparam logic [4:0] PT_P2P_HELLO    = 5'd17;
  localparam logic [4:0] PT_L1_CSNP      = 5'd24;
  localparam logic [4:0] PT_L2_CSNP      = 5'd25;

  // Header byte offsets
  localparam logic [15:0] OFF_NLPID    = 16'd0;
  localparam logic [15:0] OFF_FIXLEN   = 16'd1;
  localparam logic [15:0] OFF_VERSION  = 16'd2;
  localparam logic [15:0] OFF_IDLEN    = 16'd3;
  localparam logic [15:0] OFF_PDUTYPE  = 16'd4;
  localparam logic [15:0] OFF_PKTVER   = 16'd5;
  localparam logic [15:0] OFF_AREAS    = 16'd7;
  localparam logic [15:0] OFF_CIRCUIT  = 16'd8;
  localparam logic [15:0] OFF_HOLD_HI  = 16'(9 + SYS_ID_BYTES);
  localparam logic [15:0] OFF_HOLD_LO  = 16'(10 + SYS_ID_BYTES);
  localparam logic [15:0] OFF_PLEN_HI  = 16'(11 + SYS_ID_BYTES);
  localparam logic [15:0] OFF_PLEN_LO  = 16'(12 + SYS_ID_BYTES);

  // Error codes
  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_NLPID     = 4'd1;
  localparam logic [3:0] ERR_VERSION   = 4'd2;
  localparam logic [3:0] ERR_IDLEN     = 4'd3;
  localparam logic [3:0] ERR_HDR_SHORT = 4'd11;

  // Check flag bits: bit i stands for error code i+1
  localparam int FLAG_NLPID   = 0;
  localparam int FLAG_VERSION = 1;
  localparam int FLAG_IDLEN   = 2;
  localparam int FLAG_FIXLEN  = 3;
  localparam int FLAG_PDUTYPE = 4;
  localparam int FLAG_PKTVER  = 5;
  localparam int FLAG_AREAS   = 6;
  localparam int FLAG_CIRCUIT = 7;
  localparam int FLAG_LEVEL   = 8;
  localparam int FLAG_PLEN    = 9;
  localparam int NUM_FLAGS    = 10;

  // Byte roles
  localparam logic [2:0] ROLE_HEADER   = 3'd0;
  localparam logic [2:0] ROLE_TLV_TYPE = 3'd1;
  localparam logic [2:0] ROLE_TLV_LEN  = 3'd2;
  localparam logic [2:0] ROLE_TLV_VAL  = 3'd3;
  localparam logic [2:0] ROLE_STRAY    = 3'd4;
  localparam logic [2:0] ROLE_BEYOND   = 3'd5;
  localparam logic [2:0] ROLE_IGNORED  = 3'd6;

  localparam logic [14:0] TLV_COUNT_MAX = 15'h7FFF;
  localparam logic [15:0] OFFSET_MAX    = 16'hFFFF;

  // Lowest error code among the raised flags, zero if none
  function automatic logic [3:0] lowest_code(input logic [NUM_FLAGS-1:0] flags);
    logic [3:0] code;
    code = ERR_NONE;
    for (int i = NUM_FLAGS - 1; i >= 0; i--) begin
      if (flags[i]) begin
        code = 4'(i + 1);
      end
    end
    return code;
  endfunction

  // A known error is final once no lower-coded check is still to come
  function automatic logic settled(input logic [3:0] code, input logic [15:0] nxt);
    logic [3:0] pend;
    logic       res;
    if (nxt == OFF_NLPID) begin
      pend = ERR_NLPID;
    end else if (nxt <= OFF_VERSION) begin
      pend = ERR_VERSION;
    end else begin
      pend = ERR_IDLEN;
    end
    if (code == ERR_NONE) begin
      res = 1'b0;
    end else if (nxt >= OFF_PDUTYPE) begin
      res = 1'b1;
    end else begin
      res = (code <= pend);
    end
    return res;
  endfunction

endpackage

### rtl/isis_header_tlv_checker_unit.sv
// ----------------------------------------------------------------------------
// isis_header_tlv_checker_unit
// IS-IS PDU header checker and TLV walker, one PDU byte per request.
// ----------------------------------------------------------------------------
// Takes one PDU byte per cycle while out_stall stays low and returns one
// result per byte. Each byte goes into an input register; the header
// checks and the TLV walk step for that byte run between that register and
// the result register, so a byte may follow in every cycle and the sustained
// rate is one byte per cycle while out_stall stays low. The result for the
// byte flagged last_byte carries frame_done and the final verdict; the next
// byte starts a new frame.
module isis_header_tlv_checker_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  pdu_byte,
  input  logic [15:0] frame_length,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  byte_role,
  output logic [7:0]  tlv_kind,
  output logic [7:0]  value_index,
  output logic [3:0]  error_code,
  output logic        header_ok,
  output logic [4:0]  pdu_kind,
  output logic [15:0] hold_time,
  output logic [14:0] tlv_count,
  output logic [15:0] stragglers,
  output logic        frame_done,
  output logic        capture_short
);

  localparam logic [2:0] PH_HEAD = 3'd0;
  localparam logic [2:0] PH_TYPE = 3'd1;
  localparam logic [2:0] PH_LEN  = 3'd2;
  localparam logic [2:0] PH_VAL  = 3'd3;
  localparam logic [2:0] PH_STOP = 3'd4;

  // Input register
  logic        in_q_valid;
  logic [7:0]  in_q_byte;
  logic [15:0] in_q_flen;
  logic        in_q_last;
  logic        advance;
  logic        in_take;

  // Walk state
  logic [15:0] byte_offset, byte_offset_next;
  logic [3:0]  first_error, first_error_next;
  logic [isis_hdr_pkg::NUM_FLAGS-1:0] check_flags, check_flags_next;
  logic [4:0]  pdu_type_reg, pdu_type_reg_next;
  logic [15:0] hold_time_reg, hold_time_reg_next;
  logic [15:0] packet_length_reg, packet_length_reg_next;
  logic [15:0] remaining_bytes, remaining_bytes_next;
  logic [2:0]  walk_phase, walk_phase_next;
  logic [7:0]  current_tlv_type, current_tlv_type_next;
  logic [7:0]  value_left, value_left_next;
  logic [7:0]  value_pos, value_pos_next;
  logic [14:0] tlv_counter, tlv_counter_next;

  // Per-byte result
  logic [2:0]  res_role;
  logic [7:0]  res_kind;
  logic [7:0]  res_vidx;
  logic [3:0]  res_error;
  logic        res_hok;
  logic [4:0]  res_pdu_kind;
  logic [15:0] res_hold;
  logic [14:0] res_count;
  logic [15:0] res_strag;
  logic        res_short;

  logic [15:0] rem_dec;
  logic [15:0] walk_start;
  logic [7:0]  left_dec;
  logic [4:0]  byte_type;

  assign advance  = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_take) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q_byte <= pdu_byte;
      in_q_flen <= frame_length;
      in_q_last <= last_byte;
    end
  end

  always_comb begin
    byte_offset_next       = byte_offset;
    first_error_next       = first_error;
    check_flags_next       = check_flags;
    pdu_type_reg_next      = pdu_type_reg;
    hold_time_reg_next     = hold_time_reg;
    packet_length_reg_next = packet_length_reg;
    remaining_bytes_next   = remaining_bytes;
    walk_phase_next        = walk_phase;
    current_tlv_type_next  = current_tlv_type;
    value_left_next        = value_left;
    value_pos_next         = value_pos;
    tlv_counter_next       = tlv_counter;

    res_role   = isis_hdr_pkg::ROLE_HEADER;
    res_kind   = 8'd0;
    res_vidx   = 8'd0;
    rem_dec    = remaining_bytes - 16'd1;
    left_dec   = value_left - 8'd1;
    byte_type  = 5'(in_q_byte & isis_hdr_pkg::TYPE_MASK);
    walk_start = (pdu_type_reg == isis_hdr_pkg::PT_P2P_HELLO) ?
                 16'(isis_hdr_pkg::PTP_HDR) : 16'(isis_hdr_pkg::LAN_HDR);

    if (isis_hdr_pkg::settled(first_error, byte_offset)) begin
      res_role = isis_hdr_pkg::ROLE_IGNORED;
    end else begin
      unique case (walk_phase)
        PH_HEAD: begin
          res_role = isis_hdr_pkg::ROLE_HEADER;
          unique case (byte_offset)
            isis_hdr_pkg::OFF_NLPID: begin
              if (in_q_byte != isis_hdr_pkg::NLPID_IS)
                check_flags_next[isis_hdr_pkg::FLAG_NLPID] = 1'b1;
            end
            isis_hdr_pkg::OFF_FIXLEN: begin
              if (in_q_byte != isis_hdr_pkg::LAN_HDR && in_q_byte != isis_hdr_pkg::PTP_HDR &&
                  in_q_byte != isis_hdr_pkg::LSP_HDR && in_q_byte != isis_hdr_pkg::CSNP_HDR)
                check_flags_next[isis_hdr_pkg::FLAG_FIXLEN] = 1'b1;
            end
            isis_hdr_pkg::OFF_VERSION: begin
              if (in_q_byte != isis_hdr_pkg::VERSION_ONE)
                check_flags_next[isis_hdr_pkg::FLAG_VERSION] = 1'b1;
            end
            isis_hdr_pkg::OFF_IDLEN: begin
              if (in_q_byte != isis_hdr_pkg::ID_LEN_SYS && in_q_byte != isis_hdr_pkg::ID_LEN_DFLT)
                check_flags_next[isis_hdr_pkg::FLAG_IDLEN] = 1'b1;
            end
            isis_hdr_pkg::OFF_PDUTYPE: begin
              pdu_type_reg_next = byte_type;
              if (byte_type != isis_hdr_pkg::PT_L1_LAN_HELLO &&
                  byte_type != isis_hdr_pkg::PT_L2_LAN_HELLO &&
                  byte_type != isis_hdr_pkg::PT_P2P_HELLO &&
                  byte_type != isis_hdr_pkg::PT_L1_CSNP &&
                  byte_type != isis_hdr_pkg::PT_L2_CSNP)
                check_flags_next[isis_hdr_pkg::FLAG_PDUTYPE] = 1'b1;
            end
            isis_hdr_pkg::OFF_PKTVER: begin
              if (in_q_byte != isis_hdr_pkg::VERSION_ONE)
                check_flags_next[isis_hdr_pkg::FLAG_PKTVER] = 1'b1;
            end
            isis_hdr_pkg::OFF_AREAS: begin
              if (in_q_byte == isis_hdr_pkg::AREAS_BAD)
                check_flags_next[isis_hdr_pkg::FLAG_AREAS] = 1'b1;
            end
            isis_hdr_pkg::OFF_CIRCUIT: begin
              if (in_q_byte == isis_hdr_pkg::CIRC_NONE || in_q_byte > isis_hdr_pkg::CIRC_L12) begin
                check_flags_next[isis_hdr_pkg::FLAG_CIRCUIT] = 1'b1;
              end else if ((in_q_byte == isis_hdr_pkg::CIRC_L1 &&
                            pdu_type_reg == isis_hdr_pkg::PT_L2_LAN_HELLO) ||
                           (in_q_byte == isis_hdr_pkg::CIRC_L2 &&
                            pdu_type_reg == isis_hdr_pkg::PT_L1_LAN_HELLO)) begin
                check_flags_next[isis_hdr_pkg::FLAG_LEVEL] = 1'b1;
              end
            end
            isis_hdr_pkg::OFF_HOLD_HI: begin
              hold_time_reg_next = {in_q_byte, 8'd0};
            end
            isis_hdr_pkg::OFF_HOLD_LO: begin
              hold_time_reg_next = {hold_time_reg[15:8], in_q_byte};
            end
            isis_hdr_pkg::OFF_PLEN_HI: begin
              packet_length_reg_next = {in_q_byte, 8'd0};
            end
            isis_hdr_pkg::OFF_PLEN_LO: begin
              packet_length_reg_next = {packet_length_reg[15:8], in_q_byte};
              if (packet_length_reg_next < 16'(isis_hdr_pkg::LAN_HDR) ||
                  packet_length_reg_next > in_q_flen)
                check_flags_next[isis_hdr_pkg::FLAG_PLEN] = 1'b1;
            end
            default: begin
            end
          endcase
          first_error_next = isis_hdr_pkg::lowest_code(check_flags_next);
          if (first_error_next == isis_hdr_pkg::ERR_NONE &&
              byte_offset >= isis_hdr_pkg::OFF_PLEN_LO) begin
            if (byte_offset == isis_hdr_pkg::OFF_PLEN_LO)
              remaining_bytes_next = packet_length_reg_next - walk_start;
            // enter the walk on the last header byte
            if (byte_offset == walk_start - 16'd1)
              walk_phase_next = (remaining_bytes_next >= 16'd2) ? PH_TYPE : PH_STOP;
          end
        end
        PH_TYPE: begin
          res_role              = isis_hdr_pkg::ROLE_TLV_TYPE;
          res_kind              = in_q_byte;
          current_tlv_type_next = in_q_byte;
          remaining_bytes_next  = rem_dec;
          walk_phase_next       = PH_LEN;
        end
        PH_LEN: begin
          res_role             = isis_hdr_pkg::ROLE_TLV_LEN;
          res_kind             = current_tlv_type;
          remaining_bytes_next = rem_dec;
          if (16'(in_q_byte) > rem_dec) begin
            // overrun: stop the walk, do not count this TLV
            walk_phase_next = PH_STOP;
          end else begin
            if (tlv_counter < isis_hdr_pkg::TLV_COUNT_MAX)
              tlv_counter_next = tlv_counter + 15'd1;
            if (in_q_byte != 8'd0) begin
              value_left_next = in_q_byte;
              value_pos_next  = 8'd0;
              walk_phase_next = PH_VAL;
            end else begin
              walk_phase_next = (rem_dec >= 16'd2) ? PH_TYPE : PH_STOP;
            end
          end
        end
        PH_VAL: begin
          res_role             = isis_hdr_pkg::ROLE_TLV_VAL;
          res_kind             = current_tlv_type;
          res_vidx             = value_pos;
          value_pos_next       = value_pos + 8'd1;
          value_left_next      = left_dec;
          remaining_bytes_next = rem_dec;
          if (left_dec == 8'd0)
            walk_phase_next = (rem_dec >= 16'd2) ? PH_TYPE : PH_STOP;
        end
        default: begin
          res_role = (byte_offset < packet_length_reg) ? isis_hdr_pkg::ROLE_STRAY :
                                                         isis_hdr_pkg::ROLE_BEYOND;
        end
      endcase
    end

    byte_offset_next = (byte_offset < isis_hdr_pkg::OFFSET_MAX) ? byte_offset + 16'd1 :
                                                                  isis_hdr_pkg::OFFSET_MAX;

    // frame ended inside the header with no final verdict yet
    if (in_q_last && walk_phase_next == PH_HEAD &&
        byte_offset_next <= isis_hdr_pkg::OFF_PLEN_LO &&
        !isis_hdr_pkg::settled(first_error_next, byte_offset_next))
      first_error_next = isis_hdr_pkg::ERR_HDR_SHORT;

    res_error    = first_error_next;
    res_hok      = (first_error_next == isis_hdr_pkg::ERR_NONE) &&
                   (byte_offset_next > isis_hdr_pkg::OFF_PLEN_LO);
    res_strag    = (first_error_next == isis_hdr_pkg::ERR_NONE && walk_phase_next == PH_STOP) ?
                   remaining_bytes_next : 16'd0;
    res_short    = in_q_last && (first_error_next == isis_hdr_pkg::ERR_NONE) &&
                   (walk_phase_next != PH_STOP);
    res_pdu_kind = pdu_type_reg_next;
    res_hold     = hold_time_reg_next;
    res_count    = tlv_counter_next;

    // drop all frame state after the last byte
    if (in_q_last) begin
      byte_offset_next       = 16'd0;
      first_error_next       = isis_hdr_pkg::ERR_NONE;
      check_flags_next       = '0;
      pdu_type_reg_next      = 5'd0;
      hold_time_reg_next     = 16'd0;
      packet_length_reg_next = 16'd0;
      remaining_bytes_next   = 16'd0;
      walk_phase_next        = PH_HEAD;
      current_tlv_type_next  = 8'd0;
      value_left_next        = 8'd0;
      value_pos_next         = 8'd0;
      tlv_counter_next       = 15'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset       <= 16'd0;
      first_error       <= isis_hdr_pkg::ERR_NONE;
      check_flags       <= '0;
      pdu_type_reg      <= 5'd0;
      hold_time_reg     <= 16'd0;
      packet_length_reg <= 16'd0;
      remaining_bytes   <= 16'd0;
      walk_phase        <= PH_HEAD;
      current_tlv_type  <= 8'd0;
      value_left        <= 8'd0;
      value_pos         <= 8'd0;
      tlv_counter       <= 15'd0;
    end else if (advance) begin
      byte_offset       <= byte_offset_next;
      first_error       <= first_error_next;
      check_flags       <= check_flags_next;
      pdu_type_reg      <= pdu_type_reg_next;
      hold_time_reg     <= hold_time_reg_next;
      packet_length_reg <= packet_length_reg_next;
      remaining_bytes   <= remaining_bytes_next;
      walk_phase        <= walk_phase_next;
      current_tlv_type  <= current_tlv_type_next;
      value_left        <= value_left_next;
      value_pos         <= value_pos_next;
      tlv_counter       <= tlv_counter_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_role     <= res_role;
      tlv_kind      <= res_kind;
      value_index   <= res_vidx;
      error_code    <= res_error;
      header_ok     <= res_hok;
      pdu_kind      <= res_pdu_kind;
      hold_time     <= res_hold;
      tlv_count     <= res_count;
      stragglers    <= res_strag;
      frame_done    <= in_q_last;
      capture_short <= res_short;
    end
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IS-IS header checker and TLV walker.
// Frames go in one byte per request; an in-bench model of the header checks
// and of the TLV walk predicts every result, and a monitor compares each
// result field by field. Covers header error ordering, well-formed packets
// with random TLVs, and broken and noisy frames.
// ----------------------------------------------------------------------------
module tb_top;

  typedef enum logic [2:0] {WK_HEAD, WK_TYPE, WK_LEN, WK_VAL, WK_STOP} walk_t;

  typedef struct packed {
    logic [2:0]  role;
    logic [7:0]  kind;
    logic [7:0]  vidx;
    logic [3:0]  err;
    logic        hdr_ok;
    logic [4:0]  pkind;
    logic [15:0] hold;
    logic [14:0] count;
    logic [15:0] strag;
    logic        done;
    logic        cut_short;
  } verdict_t;

  logic        clk;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [7:0]  pdu_byte     = 8'h00;
  logic [15:0] frame_length = 16'h0000;
  logic        last_byte    = 1'b0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [2:0]  byte_role;
  logic [7:0]  tlv_kind;
  logic [7:0]  value_index;
  logic [3:0]  error_code;
  logic        header_ok;
  logic [4:0]  pdu_kind;
  logic [15:0] hold_time;
  logic [14:0] tlv_count;
  logic [15:0] stragglers;
  logic        frame_done;
  logic        capture_short;

  int idle_pct  = 0;
  int stall_pct = 0;
  int err_count = 0;

  verdict_t pending_verdicts[$];
  verdict_t oldest_verdict;

  // Model state for the frame in flight
  logic [15:0]                        rx_offset;
  logic [3:0]                         err_s;
  logic [isis_hdr_pkg::NUM_FLAGS-1:0] flag_bits;
  logic [4:0]                         ptype_s;
  logic [15:0]                        hold_s;
  logic [15:0]                        plen_s;
  logic [15:0]                        left_s;
  walk_t                              phase_s;
  logic [7:0]                         tlv_type_s;
  logic [7:0]                         val_left_s;
  logic [7:0]                         val_pos_s;
  logic [14:0]                        tlv_cnt_s;

  isis_header_tlv_checker_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic void start_new_frame();
    rx_offset  = '0;
    err_s      = isis_hdr_pkg::ERR_NONE;
    flag_bits  = '0;
    ptype_s    = '0;
    hold_s     = '0;
    plen_s     = '0;
    left_s     = '0;
    phase_s    = WK_HEAD;
    tlv_type_s = '0;
    val_left_s = '0;
    val_pos_s  = '0;
    tlv_cnt_s  = '0;
  endfunction

  function automatic logic [3:0] first_flag(input logic [isis_hdr_pkg::NUM_FLAGS-1:0] flags);
    for (int i = 0; i < isis_hdr_pkg::NUM_FLAGS; i++) begin
      if (flags[i]) begin
        return 4'(i + 1);
      end
    end
    return isis_hdr_pkg::ERR_NONE;
  endfunction

  // An error is final once no check with a lower code can still come
  function automatic bit error_final(input logic [3:0] code, input logic [15:0] nxt);
    if (code == isis_hdr_pkg::ERR_NONE) begin
      return 1'b0;
    end
    if (nxt >= isis_hdr_pkg::OFF_PDUTYPE) begin
      return 1'b1;
    end
    if (nxt == isis_hdr_pkg::OFF_NLPID) begin
      return code <= isis_hdr_pkg::ERR_NLPID;
    end
    if (nxt <= isis_hdr_pkg::OFF_VERSION) begin
      return code <= isis_hdr_pkg::ERR_VERSION;
    end
    return code <= isis_hdr_pkg::ERR_IDLEN;
  endfunction

  function automatic walk_t after_tlv();
    return (left_s >= 16'd2) ? WK_TYPE : WK_STOP;
  endfunction

  function automatic verdict_t predict_byte_verdict(input logic [7:0] b,
                                                    input logic [15:0] flen,
                                                    input logic last);
    verdict_t    v;
    logic [15:0] off;
    logic [4:0]  t;
    logic [15:0] start;
    v   = '0;
    off = rx_offset;
    if (error_final(err_s, off)) begin
      v.role = isis_hdr_pkg::ROLE_IGNORED;
    end else if (phase_s == WK_HEAD) begin
      t      = ptype_s;
      v.role = isis_hdr_pkg::ROLE_HEADER;
      case (off)
        isis_hdr_pkg::OFF_NLPID: begin
          if (b != isis_hdr_pkg::NLPID_IS) flag_bits[isis_hdr_pkg::FLAG_NLPID] = 1'b1;
        end
        isis_hdr_pkg::OFF_FIXLEN: begin
          if (b != isis_hdr_pkg::LAN_HDR && b != isis_hdr_pkg::PTP_HDR &&
              b != isis_hdr_pkg::LSP_HDR && b != isis_hdr_pkg::CSNP_HDR) begin
            flag_bits[isis_hdr_pkg::FLAG_FIXLEN] = 1'b1;
          end
        end
        isis_hdr_pkg::OFF_VERSION: begin
          if (b != isis_hdr_pkg::VERSION_ONE) flag_bits[isis_hdr_pkg::FLAG_VERSION] = 1'b1;
        end
        isis_hdr_pkg::OFF_IDLEN: begin
          if (b != isis_hdr_pkg::ID_LEN_SYS && b != isis_hdr_pkg::ID_LEN_DFLT) begin
            flag_bits[isis_hdr_pkg::FLAG_IDLEN] = 1'b1;
          end
        end
        isis_hdr_pkg::OFF_PDUTYPE: begin
          t       = b[4:0];
          ptype_s = t;
          if (t != isis_hdr_pkg::PT_L1_LAN_HELLO && t != isis_hdr_pkg::PT_L2_LAN_HELLO &&
              t != isis_hdr_pkg::PT_P2P_HELLO && t != isis_hdr_pkg::PT_L1_CSNP &&
              t != isis_hdr_pkg::PT_L2_CSNP) begin
            flag_bits[isis_hdr_pkg::FLAG_PDUTYPE] = 1'b1;
          end
        end
        isis_hdr_pkg::OFF_PKTVER: begin
          if (b != isis_hdr_pkg::VERSION_ONE) flag_bits[isis_hdr_pkg::FLAG_PKTVER] = 1'b1;
        end
        isis_hdr_pkg::OFF_AREAS: begin
          if (b == isis_hdr_pkg::AREAS_BAD) flag_bits[isis_hdr_pkg::FLAG_AREAS] = 1'b1;
        end
        isis_hdr_pkg::OFF_CIRCUIT: begin
          if (b == isis_hdr_pkg::CIRC_NONE || b > isis_hdr_pkg::CIRC_L12) begin
            flag_bits[isis_hdr_pkg::FLAG_CIRCUIT] = 1'b1;
          end else if ((b == isis_hdr_pkg::CIRC_L1 && t == isis_hdr_pkg::PT_L2_LAN_HELLO) ||
                       (b == isis_hdr_pkg::CIRC_L2 && t == isis_hdr_pkg::PT_L1_LAN_HELLO)) begin
            flag_bits[isis_hdr_pkg::FLAG_LEVEL] = 1'b1;
          end
        end
        isis_hdr_pkg::OFF_HOLD_HI: hold_s = {b, 8'h00};
        isis_hdr_pkg::OFF_HOLD_LO: hold_s[7:0] = b;
        isis_hdr_pkg::OFF_PLEN_HI: plen_s = {b, 8'h00};
        isis_hdr_pkg::OFF_PLEN_LO: begin
          plen_s[7:0] = b;
          if (plen_s < 16'(isis_hdr_pkg::LAN_HDR) || plen_s > flen) begin
            flag_bits[isis_hdr_pkg::FLAG_PLEN] = 1'b1;
          end
        end
        default: ;
      endcase
      err_s = first_flag(flag_bits);
      if (err_s == isis_hdr_pkg::ERR_NONE && off >= isis_hdr_pkg::OFF_PLEN_LO) begin
        start = (ptype_s == isis_hdr_pkg::PT_P2P_HELLO) ? 16'(isis_hdr_pkg::PTP_HDR) :
                                                          16'(isis_hdr_pkg::LAN_HDR);
        if (off == isis_hdr_pkg::OFF_PLEN_LO) begin
          left_s = plen_s - start;
        end
        if (off + 16'd1 == start) begin
          phase_s = after_tlv();
        end
      end
    end else if (phase_s == WK_TYPE) begin
      v.role     = isis_hdr_pkg::ROLE_TLV_TYPE;
      tlv_type_s = b;
      v.kind     = b;
      left_s     = left_s - 16'd1;
      phase_s    = WK_LEN;
    end else if (phase_s == WK_LEN) begin
      v.role = isis_hdr_pkg::ROLE_TLV_LEN;
      v.kind = tlv_type_s;
      left_s = left_s - 16'd1;
      // overrun: keep the length role, do not count, stop the walk
      if (16'(b) > left_s) begin
        phase_s = WK_STOP;
      end else begin
        if (tlv_cnt_s != isis_hdr_pkg::TLV_COUNT_MAX) tlv_cnt_s = tlv_cnt_s + 15'd1;
        if (b != 8'd0) begin
          val_left_s = b;
          val_pos_s  = 8'd0;
          phase_s    = WK_VAL;
        end else begin
          phase_s = after_tlv();
        end
      end
    end else if (phase_s == WK_VAL) begin
      v.role     = isis_hdr_pkg::ROLE_TLV_VAL;
      v.kind     = tlv_type_s;
      v.vidx     = val_pos_s;
      val_pos_s  = val_pos_s + 8'd1;
      val_left_s = val_left_s - 8'd1;
      left_s     = left_s - 16'd1;
      if (val_left_s == 8'd0) phase_s = after_tlv();
    end else begin
      v.role = (off < plen_s) ? isis_hdr_pkg::ROLE_STRAY : isis_hdr_pkg::ROLE_BEYOND;
    end

    rx_offset = (off != isis_hdr_pkg::OFFSET_MAX) ? off + 16'd1 : off;

    if (last && phase_s == WK_HEAD && rx_offset <= isis_hdr_pkg::OFF_PLEN_LO &&
        !error_final(err_s, rx_offset)) begin
      err_s = isis_hdr_pkg::ERR_HDR_SHORT;
    end

    v.err       = err_s;
    v.hdr_ok    = (err_s == isis_hdr_pkg::ERR_NONE) && (rx_offset > isis_hdr_pkg::OFF_PLEN_LO);
    v.pkind     = ptype_s;
    v.hold      = hold_s;
    v.count     = tlv_cnt_s;
    v.strag     = (err_s == isis_hdr_pkg::ERR_NONE && phase_s == WK_STOP) ? left_s : 16'd0;
    v.done      = last;
    v.cut_short = last && (err_s == isis_hdr_pkg::ERR_NONE) && (phase_s != WK_STOP);
    if (last) start_new_frame();
    return v;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      err_count++;
      if (err_count <= 100) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        err_count++;
        if (err_count <= 100) begin
          $display("%0t ns: result with no request pending, expected none, actual role %0d",
                   $time, byte_role);
        end
      end else begin
        oldest_verdict = pending_verdicts.pop_front();
        check_field("byte_role", oldest_verdict.role, byte_role);
        check_field("tlv_kind", oldest_verdict.kind, tlv_kind);
        check_field("value_index", oldest_verdict.vidx, value_index);
        check_field("error_code", oldest_verdict.err, error_code);
        check_field("header_ok", oldest_verdict.hdr_ok, header_ok);
        check_field("pdu_kind", oldest_verdict.pkind, pdu_kind);
        check_field("hold_time", oldest_verdict.hold, hold_time);
        check_field("tlv_count", oldest_verdict.count, tlv_count);
        check_field("stragglers", oldest_verdict.strag, stragglers);
        check_field("frame_done", oldest_verdict.done, frame_done);
        check_field("capture_short", oldest_verdict.cut_short, capture_short);
      end
    end
  end

  // Send one request; hold the payload until it is taken
  task automatic push_pdu_byte(input logic [7:0] b, input logic [15:0] flen,
                               input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    pdu_byte     <= b;
    frame_length <= flen;
    last_byte    <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_verdicts.push_back(predict_byte_verdict(b, flen, last));
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic send_frame(input logic [7:0] pk[$], input logic [15:0] flen);
    for (int i = 0; i < pk.size(); i++) begin
      push_pdu_byte(pk[i], flen, i == pk.size() - 1);
    end
  endtask

  // First byte sits in the top byte of the n used
  task automatic send_short_frame(input logic [63:0] seq, input int n,
                                  input logic [15:0] flen);
    for (int i = 0; i < n; i++) begin
      push_pdu_byte(seq[8*(n-1-i) +: 8], flen, i == n - 1);
    end
  endtask

  task automatic build_header(ref logic [7:0] pk[$], input logic [4:0] ptype,
                              input logic [15:0] plen);
    int start;
    start = (ptype == isis_hdr_pkg::PT_P2P_HELLO) ? int'(isis_hdr_pkg::PTP_HDR) :
                                                    int'(isis_hdr_pkg::LAN_HDR);
    pk.delete();
    pk.push_back(isis_hdr_pkg::NLPID_IS);
    case ($urandom_range(3))
      0: pk.push_back(isis_hdr_pkg::LAN_HDR);
      1: pk.push_back(isis_hdr_pkg::PTP_HDR);
      2: pk.push_back(isis_hdr_pkg::LSP_HDR);
      default: pk.push_back(isis_hdr_pkg::CSNP_HDR);
    endcase
    pk.push_back(isis_hdr_pkg::VERSION_ONE);
    pk.push_back($urandom_range(1) ? isis_hdr_pkg::ID_LEN_SYS : isis_hdr_pkg::ID_LEN_DFLT);
    pk.push_back({3'($urandom), ptype});
    pk.push_back(isis_hdr_pkg::VERSION_ONE);
    pk.push_back(8'($urandom));
    pk.push_back(8'($urandom_range(254, 0)));
    if (ptype == isis_hdr_pkg::PT_L1_LAN_HELLO) begin
      pk.push_back($urandom_range(1) ? isis_hdr_pkg::CIRC_L1 : isis_hdr_pkg::CIRC_L12);
    end else if (ptype == isis_hdr_pkg::PT_L2_LAN_HELLO) begin
      pk.push_back($urandom_range(1) ? isis_hdr_pkg::CIRC_L2 : isis_hdr_pkg::CIRC_L12);
    end else begin
      pk.push_back(8'($urandom_range(3, 1)));
    end
    repeat (isis_hdr_pkg::SYS_ID_BYTES) pk.push_back(8'($urandom));
    pk.push_back(8'($urandom));
    pk.push_back(8'($urandom));
    pk.push_back(plen[15:8]);
    pk.push_back(plen[7:0]);
    while (pk.size() < start) pk.push_back(8'($urandom));
  endtask

  task automatic add_tlvs(ref logic [7:0] pk[$], input int body, input bit allow_bad,
                          input int cap);
    int r;
    int len;
    int top;
    r = body;
    while (r > 0) begin
      if (r == 1) begin
        pk.push_back(8'($urandom));
        r = 0;
      end else if (allow_bad && r - 2 < 255 && $urandom_range(15) == 0) begin
        // length runs past the packet end
        pk.push_back(8'($urandom));
        pk.push_back(8'($urandom_range(255, r - 1)));
        repeat (r - 2) pk.push_back(8'($urandom));
        r = 0;
      end else begin
        top = (r - 2 < cap) ? r - 2 : cap;
        len = $urandom_range(top, 0);
        pk.push_back(8'($urandom));
        pk.push_back(8'(len));
        repeat (len) pk.push_back(8'($urandom));
        r -= len + 2;
      end
    end
  endtask

  task automatic send_random_frame(output int n);
    logic [7:0]  pk[$];
    logic [4:0]  ptype;
    logic [15:0] plen;
    logic [15:0] flen;
    logic [15:0] hdr_offsets[10];
    int          start;
    int          body;
    int          mode;
    hdr_offsets = '{isis_hdr_pkg::OFF_NLPID, isis_hdr_pkg::OFF_FIXLEN,
                    isis_hdr_pkg::OFF_VERSION, isis_hdr_pkg::OFF_IDLEN,
                    isis_hdr_pkg::OFF_PDUTYPE, isis_hdr_pkg::OFF_PKTVER,
                    isis_hdr_pkg::OFF_AREAS, isis_hdr_pkg::OFF_CIRCUIT,
                    isis_hdr_pkg::OFF_PLEN_HI, isis_hdr_pkg::OFF_PLEN_LO};
    mode = $urandom_range(99);
    if (mode < 10) begin
      // line noise, sometimes with a good protocol id
      repeat ($urandom_range(40, 1)) pk.push_back(8'($urandom));
      if ($urandom_range(1)) pk[0] = isis_hdr_pkg::NLPID_IS;
      flen = 16'($urandom);
    end else begin
      case ($urandom_range(4))
        0: ptype = isis_hdr_pkg::PT_L1_LAN_HELLO;
        1: ptype = isis_hdr_pkg::PT_L2_LAN_HELLO;
        2: ptype = isis_hdr_pkg::PT_P2P_HELLO;
        3: ptype = isis_hdr_pkg::PT_L1_CSNP;
        default: ptype = isis_hdr_pkg::PT_L2_CSNP;
      endcase
      start = (ptype == isis_hdr_pkg::PT_P2P_HELLO) ? int'(isis_hdr_pkg::PTP_HDR) :
                                                      int'(isis_hdr_pkg::LAN_HDR);
      body  = ($urandom_range(7) == 0) ? $urandom_range(600, 0) : $urandom_range(60, 0);
      plen  = 16'(start + body);
      build_header(pk, ptype, plen);
      add_tlvs(pk, body, 1'b1, ($urandom_range(7) == 0) ? 255 : 12);
      case ($urandom_range(19))
        0: flen = 16'($urandom_range(plen - 16'd1, 0));
        1, 2, 3, 4: flen = 16'($urandom_range(65535, plen));
        default: flen = plen;
      endcase
      if (mode < 22) begin
        pk[hdr_offsets[$urandom_range(9)]] = 8'($urandom);
      end
      case ($urandom_range(7))
        0: repeat ($urandom_range(8, 1)) pk.push_back(8'($urandom));
        1: begin
          body = $urandom_range(pk.size() - 1, 1);
          while (pk.size() > body) void'(pk.pop_back());
        end
        default: ;
      endcase
    end
    n = pk.size();
    send_frame(pk, flen);
  endtask

  task automatic test_header_error_order();
    idle_pct  = 0;
    stall_pct = 0;
    send_short_frame(64'h00, 1, 16'h0000);
    send_short_frame(64'hFF_FF_FF, 3, 16'hFFFF);
    send_short_frame({56'h0, isis_hdr_pkg::NLPID_IS}, 1, 16'h8000);
    // fixed length fails first, then version takes over
    send_short_frame(64'h83_05_02_06, 4, 16'h00FF);
    send_short_frame(64'h83_05_01_09_00, 5, 16'h7FFF);
    send_short_frame(64'h83_14_01_00_FF, 5, 16'h0100);
    send_short_frame(64'h83_1B_01_06_0F_01, 6, 16'h001B);
    wait_all_results();
  endtask

  task automatic test_random_traffic();
    int sent;
    int n;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 49; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      sent = 0;
      while (sent < 150) begin
        send_random_frame(n);
        sent += n;
      end
      wait_all_results();
    end
  endtask

  initial begin
    start_new_frame();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_header_error_order();
    test_random_traffic();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
